// ===== src/ncd_pkg.sv =====
package ncd_pkg;

  // Result width and limits
  localparam int OUT_W = 48;
  localparam logic [OUT_W-1:0] Q_MAX_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] Q_MAX_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // Control bits that travel alongside the data from the front end's last stage through every divider cell
  typedef struct packed {
    logic valid;
    logic neg;
    logic bad;
    logic ovf;
  } ctl_t;

endpackage

// ===== src/ncd_if.sv =====
interface ncd_in_if #(
  parameter int SAMPLE_BITS  = 24,
  parameter int SPACING_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_BITS-1:0]  sample_center;
  logic signed [SAMPLE_BITS-1:0]  sample_minus;
  logic signed [SAMPLE_BITS-1:0]  sample_plus;
  logic [SPACING_BITS-1:0]        spacing_minus;
  logic [SPACING_BITS-1:0]        spacing_plus;

  modport source (output valid, sample_center, sample_minus, sample_plus,
                  spacing_minus, spacing_plus, input ready);
  modport sink (input valid, sample_center, sample_minus, sample_plus,
                spacing_minus, spacing_plus, output ready);
endinterface

interface ncd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ncd_pkg::OUT_W-1:0] derivative;
  logic                             saturated;
  logic                             bad_spacing;

  modport source (output valid, derivative, saturated, bad_spacing, input ready);
  modport sink (input valid, derivative, saturated, bad_spacing, output ready);
endinterface

// ===== src/nonuniform_central_difference_unit.sv =====
// Channel  Dir  Payload
// din      in   sample_center, sample_minus, sample_plus, spacing_minus, spacing_plus
// dout     out  derivative, saturated, bad_spacing
//
// Throughput one transaction per cycle while dout is not stalled. Each result passes through
// the front stages, the row of divider cells (one per quotient bit) and the output register.
// Synchronous active-high reset clears all valid bits.
// The whole pipeline advances together; it holds only while a result waits at dout.
module nonuniform_central_difference_unit #(
  parameter int SAMPLE_BITS  = 24,
  parameter int SPACING_BITS = 16,
  parameter int FRAC_BITS    = 16
) (
  input logic clk,
  input logic rst,
  ncd_in_if.sink  din,
  ncd_out_if.source dout
);
  localparam int NW    = SAMPLE_BITS + 2*SPACING_BITS + 2;
  localparam int DW    = 3*SPACING_BITS + 1;
  localparam int QW    = NW + FRAC_BITS;
  localparam int OUT_W = ncd_pkg::OUT_W;

  logic              adv;
  ncd_pkg::ctl_t     ctl [QW+1];
  logic [QW-1:0]     num [QW+1];
  logic [DW-1:0]     rem [QW+1];
  logic [DW-1:0]     den [QW+1];
  logic [OUT_W-1:0]  q   [QW+1];
  logic [NW-1:0]     num_mag;
  logic              sat;

  assign adv       = !(dout.valid && !dout.ready);
  assign din.ready = adv;

  ncd_front #(.SB(SAMPLE_BITS), .SPB(SPACING_BITS), .NW(NW), .DW(DW)) u_front (
    .clk, .rst, .adv,
    .in_valid(din.valid),
    .c(din.sample_center), .m(din.sample_minus), .p(din.sample_plus),
    .dm(din.spacing_minus), .dp(din.spacing_plus),
    .ctl(ctl[0]), .num_mag(num_mag), .den(den[0])
  );

  assign num[0] = QW'(num_mag) << FRAC_BITS;
  assign rem[0] = '0;
  assign q[0]   = '0;

  // divider row
  for (genvar i = 0; i < QW; i++) begin : g_cell
    ncd_cell #(.QW(QW), .DW(DW)) u_cell (
      .clk, .rst, .adv,
      .ctl_in(ctl[i]), .num_in(num[i]), .rem_in(rem[i]), .den_in(den[i]), .q_in(q[i]),
      .ctl_out(ctl[i+1]), .num_out(num[i+1]), .rem_out(rem[i+1]),
      .den_out(den[i+1]), .q_out(q[i+1])
    );
  end

  // saturation: the negative side reaches one step further
  always_comb begin
    if (ctl[QW].neg) begin
      sat = ctl[QW].ovf || (q[QW] > ncd_pkg::Q_MAX_NEG);
    end else begin
      sat = ctl[QW].ovf || (q[QW] > ncd_pkg::Q_MAX_POS);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= ctl[QW].valid;
    end
    if (adv) begin
      dout.bad_spacing <= ctl[QW].bad;
      dout.saturated   <= !ctl[QW].bad && sat;
      if (ctl[QW].bad) begin
        dout.derivative <= '0;
      end else if (sat) begin
        dout.derivative <= ctl[QW].neg ? ncd_pkg::Q_MAX_NEG : ncd_pkg::Q_MAX_POS;
      end else begin
        dout.derivative <= ctl[QW].neg ? -q[QW] : q[QW];
      end
    end
  end
endmodule

// ===== src/ncd_front.sv =====
// Numerator and denominator, three registered stages
module ncd_front #(
  parameter int SB  = 24,
  parameter int SPB = 16,
  parameter int NW  = SB + 2*SPB + 2,
  parameter int DW  = 3*SPB + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [SB-1:0] c,
  input  logic signed [SB-1:0] m,
  input  logic signed [SB-1:0] p,
  input  logic [SPB-1:0]       dm,
  input  logic [SPB-1:0]       dp,
  output ncd_pkg::ctl_t        ctl,
  output logic [NW-1:0]        num_mag,
  output logic [DW-1:0]        den
);
  localparam int PW = SB + 2*SPB + 1;

  // stage 1: squares, product and sum of spacings
  logic                 v1, bad1;
  logic signed [SB-1:0] c1, m1, p1;
  logic [2*SPB-1:0]     dm2, dp2, dpdm;
  logic [SPB:0]         dsum;
  // stage 2: signed terms and denominator
  logic                 v2, bad2;
  logic signed [PW-1:0] tp, tm, tc;
  logic [DW-1:0]        den2;
  // stage 3: numerator magnitude and sign
  logic signed [NW-1:0] num_s;

  always_comb begin
    num_s = NW'(tp) - NW'(tm) + NW'(tc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      ctl.valid <= v2;
    end
    if (adv) begin
      bad1 <= (dm == '0) || (dp == '0);
      c1   <= c;
      m1   <= m;
      p1   <= p;
      dm2  <= dm * dm;
      dp2  <= dp * dp;
      dpdm <= dm * dp;
      dsum <= {1'b0, dm} + {1'b0, dp};

      bad2 <= bad1;
      tp   <= PW'(p1) * $signed({1'b0, dm2});
      tm   <= PW'(m1) * $signed({1'b0, dp2});
      tc   <= PW'(c1) * ($signed({1'b0, dp2}) - $signed({1'b0, dm2}));
      den2 <= DW'(dpdm) * DW'(dsum);

      ctl.bad <= bad2;
      ctl.ovf <= 1'b0;
      ctl.neg <= num_s[NW-1];
      num_mag <= num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
      den     <= den2;
    end
  end
endmodule

// ===== src/ncd_cell.sv =====
// One restoring-division step: one quotient bit per cell
module ncd_cell #(
  parameter int QW = 74,
  parameter int DW = 49
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  ncd_pkg::ctl_t               ctl_in,
  input  logic [QW-1:0]               num_in,
  input  logic [DW-1:0]               rem_in,
  input  logic [DW-1:0]               den_in,
  input  logic [ncd_pkg::OUT_W-1:0]   q_in,
  output ncd_pkg::ctl_t               ctl_out,
  output logic [QW-1:0]               num_out,
  output logic [DW-1:0]               rem_out,
  output logic [DW-1:0]               den_out,
  output logic [ncd_pkg::OUT_W-1:0]   q_out
);
  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;
  logic        qbit;

  always_comb begin
    rem_sh  = {rem_in, num_in[QW-1]};
    qbit    = rem_sh >= {1'b0, den_in};
    rem_sub = rem_sh - {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (adv) begin
      ctl_out.neg <= ctl_in.neg;
      ctl_out.bad <= ctl_in.bad;
      // a bit shifted out of the result window means overflow
      ctl_out.ovf <= ctl_in.ovf | q_in[ncd_pkg::OUT_W-1];
      q_out   <= {q_in[ncd_pkg::OUT_W-2:0], qbit};
      rem_out <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      num_out <= {num_in[QW-2:0], 1'b0};
      den_out <= den_in;
    end
  end
endmodule

// ===== bench/nonuniform_central_difference_unit_tb.sv =====
`timescale 1ns / 100ps

module nonuniform_central_difference_unit_tb;

  localparam int SB = 24;
  localparam int DB = 16;
  localparam int FB = 16;
  localparam int LATENCY = 4 + SB + 2 * DB + 2 + FB;

  typedef struct {
    logic signed [SB-1:0] center;
    logic signed [SB-1:0] minus;
    logic signed [SB-1:0] plus;
    logic [DB-1:0] dm;
    logic [DB-1:0] dp;
  } stencil_t;

  typedef struct {
    logic signed [ncd_pkg::OUT_W-1:0] deriv;
    logic sat;
    logic bad;
  } deriv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic failed = 1'b0;
  logic drain_hold = 1'b0;
  logic stim_done = 1'b0;

  ncd_in_if #(.SAMPLE_BITS(SB), .SPACING_BITS(DB)) din ();
  ncd_out_if dout ();

  nonuniform_central_difference_unit #(
    .SAMPLE_BITS(SB), .SPACING_BITS(DB), .FRAC_BITS(FB)
  ) dut (
    .clk(clk), .rst(rst), .din(din.sink), .dout(dout.source)
  );

  stencil_t pending_points[$];
  deriv_t expected_derivs[$];

  // Exact non-uniform difference, truncated toward zero and clipped
  function automatic deriv_t central_diff(stencil_t s);
    deriv_t r;
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] q;
    logic signed [127:0] c, m, p, dm, dp;
    r.deriv = '0;
    r.sat = 1'b0;
    r.bad = 1'b0;
    if (s.dm == 0 || s.dp == 0) begin
      r.bad = 1'b1;
      return r;
    end
    c = s.center;
    m = s.minus;
    p = s.plus;
    dm = {1'b0, s.dm};
    dp = {1'b0, s.dp};
    num = p * dm * dm - m * dp * dp + c * (dp * dp - dm * dm);
    num = num <<< FB;
    den = dp * dm * (dp + dm);
    q = num / den;  // truncates toward zero
    if (q > $signed({80'd0, ncd_pkg::Q_MAX_POS})) begin
      r.deriv = ncd_pkg::Q_MAX_POS;
      r.sat = 1'b1;
    end else if (q < -$signed({80'd0, ncd_pkg::Q_MAX_NEG})) begin
      r.deriv = ncd_pkg::Q_MAX_NEG;
      r.sat = 1'b1;
    end else begin
      r.deriv = q[ncd_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SB-1){1'b1}}};
      1: return {1'b1, {(SB-1){1'b0}}};
      2: return SB'($urandom_range(0, 15)) - SB'(8);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [DB-1:0] pick_spacing();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DB'(1);
      3, 4: return DB'($urandom_range(1, 8));
      default: return DB'($urandom);
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus: directed corners, then random points
  initial begin
    stencil_t s;
    logic [SB-1:0] ext[4];
    logic [DB-1:0] sp[3];
    ext[0] = {1'b0, {(SB-1){1'b1}}};
    ext[1] = {1'b1, {(SB-1){1'b0}}};
    ext[2] = '0;
    ext[3] = '1;
    sp[0] = '0;
    sp[1] = '1;
    sp[2] = DB'(1);
    for (int i = 0; i < 24; i++) begin
      s.center = ext[i % 4];
      s.minus = ext[(i / 4) % 4];
      s.plus = ext[(i + 1) % 4];
      s.dm = sp[i % 3];
      s.dp = sp[(i / 3) % 3];
      pending_points.push_back(s);
    end
    for (int i = 0; i < 1150; i++) begin
      s.center = pick_sample();
      s.minus = pick_sample();
      s.plus = pick_sample();
      s.dm = pick_spacing();
      s.dp = pick_spacing();
      pending_points.push_back(s);
    end
    stim_done = 1'b1;
  end

  // Driver; after 600 transactions the sender drains before continuing
  int gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      din.valid <= 1'b0;
    end else begin
      if (din.valid && din.ready) begin
        expected_derivs.push_back(central_diff('{din.sample_center, din.sample_minus,
          din.sample_plus, din.spacing_minus, din.spacing_plus}));
        sent++;
      end
      if (din.valid && !din.ready) begin
        // hold current transaction
      end else if (sent == 600 && !drain_hold) begin
        din.valid <= 1'b0;
        if (expected_derivs.size() == 0 && !(din.valid && din.ready)) drain_hold <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        din.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        stencil_t s;
        s = pending_points.pop_front();
        din.sample_center <= s.center;
        din.sample_minus <= s.minus;
        din.sample_plus <= s.plus;
        din.spacing_minus <= s.dm;
        din.spacing_plus <= s.dp;
        din.valid <= 1'b1;
        gap = gap_len();
      end else begin
        din.valid <= 1'b0;
      end
    end
  end

  // Monitor and sink stalls
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
    end else begin
      if (dout.valid && dout.ready) begin
        if (expected_derivs.size() == 0) begin
          $display("%0t: unexpected result %h", $time, dout.derivative);
          failed <= 1'b1;
        end else begin
          deriv_t e;
          e = expected_derivs.pop_front();
          if (dout.derivative !== e.deriv || dout.saturated !== e.sat
              || dout.bad_spacing !== e.bad) begin
            $display("%0t: expected deriv=%h sat=%b bad=%b, actual deriv=%h sat=%b bad=%b",
                     $time, e.deriv, e.sat, e.bad, dout.derivative, dout.saturated,
                     dout.bad_spacing);
            failed <= 1'b1;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  initial begin
    din.valid = 1'b0;
    din.sample_center = '0;
    din.sample_minus = '0;
    din.sample_plus = '0;
    din.spacing_minus = '0;
    din.spacing_plus = '0;
    dout.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_points.size() == 0);
    @(posedge clk);
    while (din.valid || expected_derivs.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && expected_derivs.size() == 0) begin
      $display("** nonuniform_central_difference_unit: PASSED **");
    end else begin
      $display("** nonuniform_central_difference_unit: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("** nonuniform_central_difference_unit: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ncd_pkg.sv
src/ncd_if.sv
src/ncd_front.sv
src/ncd_cell.sv
src/nonuniform_central_difference_unit.sv
bench/nonuniform_central_difference_unit_tb.sv
